[rtl/svtc_pkg.sv]
// shared types and character constants for the sparse vector token counter
package svtc_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [1:0] code_t;
	typedef logic [1:0] status_t;

	// characters that steer the scan
	localparam byte_t CH_COMMA  = 8'h2C;
	localparam byte_t CH_SPACE  = 8'h20;
	localparam byte_t CH_TAB    = 8'h09;
	localparam byte_t CH_COLON  = 8'h3A;
	localparam byte_t CH_ZERO   = 8'h30;
	localparam byte_t CH_QUOTE  = 8'h22;
	localparam byte_t CH_LPAREN = 8'h28;
	localparam byte_t CH_RPAREN = 8'h29;
	localparam byte_t CH_LSQ    = 8'h5B;
	localparam byte_t CH_RSQ    = 8'h5D;
	localparam byte_t CH_LCURLY = 8'h7B;
	localparam byte_t CH_RCURLY = 8'h7D;

	// nesting stack entry codes
	localparam code_t CODE_PAREN  = 2'd0;
	localparam code_t CODE_SQUARE = 2'd1;
	localparam code_t CODE_CURLY  = 2'd2;
	localparam code_t CODE_QUOTE  = 2'd3;

	// result status codes
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_MISMATCH = 2'd1;
	localparam status_t ST_OVERFLOW = 2'd2;

endpackage

[rtl/svtc_in_if.sv]
// character input channel: one byte of the line per transaction
interface svtc_in_if;
	logic                valid;
	logic                ready;
	svtc_pkg::byte_t     in_byte;
	logic                last;

	modport source (output valid, output in_byte, output last, input ready);
	modport sink (input valid, input in_byte, input last, output ready);
endinterface

[rtl/svtc_out_if.sv]
// result channel: one rewritten byte with running count and status per transaction
interface svtc_out_if;
	logic                valid;
	logic                ready;
	svtc_pkg::byte_t     out_byte;
	logic [15:0]         count;
	svtc_pkg::status_t   status;
	logic                done_res;

	modport source (output valid, output out_byte, output count, output status,
		output done_res, input ready);
	modport sink (input valid, input out_byte, input count, input status,
		input done_res, output ready);
endinterface

[rtl/sparse_vector_token_counter.sv]
// top level: scans a vector text line byte by byte, rewrites separators and counts tokens
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+------------------------------------------
//   chars     | in  | valid/ready   | in_byte[7:0], last
//   results   | out | valid/ready   | out_byte[7:0], count[15:0], status[1:0], done_res
//   cfg       | in  | cfg_we        | cfg_wdata (count_all)
//
// one byte per cycle unless results stall: each byte is decided combinationally from
// the line state and lands in the result register; the nesting stack keeps its top
// and the entry under it in registers so a pop needs no memory read in the same cycle
// a new byte is taken whenever the result register is empty or being drained
// arst_n clears line state and count_all; the stack memory has no reset
// line state returns to reset values after the byte marked last
module sparse_vector_token_counter #(
	parameter int NEST_DEPTH = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	svtc_in_if.sink     chars,
	svtc_out_if.source  results
);
	import svtc_pkg::*;

	localparam int LVL_W = $clog2(NEST_DEPTH + 1);
	localparam int IDX_W = $clog2(NEST_DEPTH);
	localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(NEST_DEPTH);
	localparam logic [LVL_W-1:0] LVL_TWO  = LVL_W'(2);

	// line state
	logic                  count_all_q;
	logic [LVL_W-1:0]      level_q, level_n;
	logic                  in_quote_q, in_quote_n;
	logic                  in_gap_q, in_gap_n;
	logic [1:0]            span_len_q, span_len_n;
	logic [15:0]           span_tail_q, span_tail_n;
	logic                  fzp_q, fzp_n;
	logic                  fwz_q, fwz_n;
	logic [COUNT_BITS-1:0] token_q, token_n;
	status_t               status_q, status_n;

	// nesting stack
	code_t                 stk_mem [NEST_DEPTH];
	code_t                 top_q, top_n;
	code_t                 below_q;
	logic                  push_en;
	code_t                 push_code;
	logic [LVL_W-1:0]      rd_lvl;
	logic [IDX_W-1:0]      rd_idx;

	// result register
	logic                  out_valid_q;
	byte_t                 out_byte_q;
	logic [15:0]           out_count_q;
	status_t               out_status_q;
	logic                  out_done_q;

	// per-byte decision
	logic                  accept;
	byte_t                 b, ob;
	logic                  lst;
	logic                  at_top, is_sep, sep_break, restart;
	logic [15:0]           psh_tail, st_tail, ev_tail;
	logic [1:0]            psh_len, ev_len;
	logic                  do_eval, ev_zero, bump;
	code_t                 want;
	logic [31:0]           token_ext;

	assign chars.ready = !out_valid_q || results.ready;
	assign accept      = chars.valid && chars.ready;
	assign b           = chars.in_byte;
	assign lst         = chars.last;

	always_comb begin
		ob          = b;
		level_n     = level_q;
		in_quote_n  = in_quote_q;
		in_gap_n    = in_gap_q;
		span_len_n  = span_len_q;
		span_tail_n = span_tail_q;
		fzp_n       = fzp_q;
		fwz_n       = fwz_q;
		token_n     = token_q;
		status_n    = status_q;
		top_n       = top_q;
		push_en     = 1'b0;
		push_code   = CODE_PAREN;
		at_top      = (level_q == '0);
		is_sep      = (b == CH_COMMA) || (b == CH_SPACE) || (b == CH_TAB);
		sep_break   = 1'b0;
		restart     = 1'b0;
		do_eval     = 1'b0;
		ev_zero     = 1'b0;
		bump        = 1'b0;
		want        = CODE_PAREN;
		ev_tail     = span_tail_q;
		ev_len      = span_len_q;
		psh_tail    = 16'h0000;
		psh_len     = 2'd0;
		st_tail     = 16'h0000;
		if (status_q == ST_OK) begin
			if (at_top && is_sep) begin
				ob = CH_SPACE;
			end
			sep_break = at_top && is_sep && !in_gap_q;
			restart   = at_top && !is_sep && in_gap_q;
			if (at_top) begin
				in_gap_n = is_sep;
			end

			psh_tail = {span_tail_q[7:0], ob};
			psh_len  = (span_len_q == 2'd2) ? 2'd2 : span_len_q + 2'd1;
			st_tail  = {8'h00, ob};

			// token bookkeeping: last byte evaluates the updated span, a break the old one
			priority if (lst) begin
				span_tail_n = restart ? st_tail : psh_tail;
				span_len_n  = restart ? 2'd1 : psh_len;
				ev_tail     = span_tail_n;
				ev_len      = span_len_n;
				do_eval     = 1'b1;
			end else if (sep_break) begin
				do_eval     = (span_len_q != 2'd0);
				span_tail_n = st_tail;
				span_len_n  = 2'd1;
			end else if (restart) begin
				span_tail_n = st_tail;
				span_len_n  = 2'd1;
			end else begin
				span_tail_n = psh_tail;
				span_len_n  = psh_len;
			end

			ev_zero = (ev_tail[7:0] == CH_ZERO) &&
				((ev_len == 2'd1) || ((ev_len == 2'd2) && (ev_tail[15:8] == CH_COLON)));
			if (do_eval) begin
				fwz_n = 1'b0;
				priority if (count_all_q || !ev_zero) begin
					bump = 1'b1;
				end else if (fzp_q) begin
					bump  = 1'b1;
					fzp_n = 1'b0;
				end else begin
					fwz_n = 1'b1;
				end
			end

			// bracket and quote nesting
			if (!in_quote_q) begin
				priority if (b == CH_QUOTE || b == CH_LPAREN || b == CH_LSQ
						|| b == CH_LCURLY) begin
					priority if (b == CH_QUOTE) begin
						push_code  = CODE_QUOTE;
						in_quote_n = 1'b1;
					end else if (b == CH_LPAREN) begin
						push_code = CODE_PAREN;
					end else if (b == CH_LSQ) begin
						push_code = CODE_SQUARE;
					end else begin
						push_code = CODE_CURLY;
					end
					if (level_q != LVL_FULL) begin
						push_en = 1'b1;
						level_n = level_q + LVL_W'(1);
						top_n   = push_code;
					end else begin
						status_n = ST_OVERFLOW;
					end
				end else if (b == CH_RPAREN || b == CH_RSQ || b == CH_RCURLY) begin
					priority if (b == CH_RPAREN) begin
						want = CODE_PAREN;
					end else if (b == CH_RSQ) begin
						want = CODE_SQUARE;
					end else begin
						want = CODE_CURLY;
					end
					// close on an empty stack is ignored
					if (!at_top) begin
						if (top_q == want) begin
							level_n = level_q - LVL_W'(1);
							top_n   = below_q;
						end else begin
							status_n = ST_MISMATCH;
						end
					end
				end else begin
				end
			end else if (b == CH_QUOTE) begin
				if (!at_top) begin
					level_n = level_q - LVL_W'(1);
					top_n   = below_q;
				end else begin
					status_n = ST_MISMATCH;
				end
				in_quote_n = 1'b0;
			end

			// a trailing uncounted zero still counts at end of line
			if (lst && status_n == ST_OK && fwz_n && !count_all_q) begin
				bump = 1'b1;
			end
			if (bump && !(&token_q)) begin
				token_n = token_q + COUNT_BITS'(1);
			end
		end
	end

	assign token_ext = 32'(token_n);

	// keep below_q pointing at the entry under the top for the level seen next cycle
	always_comb begin
		if (accept) begin
			rd_lvl = lst ? '0 : level_n;
		end else begin
			rd_lvl = level_q;
		end
		rd_idx = (rd_lvl >= LVL_TWO) ? IDX_W'(rd_lvl - LVL_TWO) : '0;
	end

	always_ff @(posedge clk) begin
		if (accept && push_en) begin
			stk_mem[level_q[IDX_W-1:0]] <= push_code;
		end
		below_q <= stk_mem[rd_idx];
		if (accept) begin
			top_q        <= top_n;
			out_byte_q   <= ob;
			out_count_q  <= token_ext[15:0];
			out_status_q <= status_n;
			out_done_q   <= lst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_all_q <= 1'b0;
			out_valid_q <= 1'b0;
			level_q     <= '0;
			in_quote_q  <= 1'b0;
			in_gap_q    <= 1'b0;
			span_len_q  <= 2'd0;
			span_tail_q <= 16'h0000;
			fzp_q       <= 1'b1;
			fwz_q       <= 1'b0;
			token_q     <= '0;
			status_q    <= ST_OK;
		end else begin
			if (cfg_we) begin
				count_all_q <= cfg_wdata;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (lst) begin
					level_q     <= '0;
					in_quote_q  <= 1'b0;
					in_gap_q    <= 1'b0;
					span_len_q  <= 2'd0;
					span_tail_q <= 16'h0000;
					fzp_q       <= 1'b1;
					fwz_q       <= 1'b0;
					token_q     <= '0;
					status_q    <= ST_OK;
				end else begin
					level_q     <= level_n;
					in_quote_q  <= in_quote_n;
					in_gap_q    <= in_gap_n;
					span_len_q  <= span_len_n;
					span_tail_q <= span_tail_n;
					fzp_q       <= fzp_n;
					fwz_q       <= fwz_n;
					token_q     <= token_n;
					status_q    <= status_n;
				end
			end
		end
	end

	assign results.valid    = out_valid_q;
	assign results.out_byte = out_byte_q;
	assign results.count    = out_count_q;
	assign results.status   = out_status_q;
	assign results.done_res = out_done_q;

endmodule

[rtl/svtc_checker.sv]
// port-level checks for the sparse vector token counter, bound to the top level
module svtc_checker #(
	parameter int COUNT_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic [15:0] count,
	input logic [1:0]  status,
	input logic        done_res
);
	import svtc_pkg::*;

	logic        out_acc;
	logic        prev_done_q;
	status_t     prev_status_q;
	logic [15:0] prev_count_q;

	assign out_acc = out_valid && out_ready;

	// remember the previous delivered result within the line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_done_q   <= 1'b1;
			prev_status_q <= ST_OK;
			prev_count_q  <= 16'h0000;
		end else if (out_acc) begin
			prev_done_q   <= done_res;
			prev_status_q <= status;
			prev_count_q  <= count;
		end
	end

	// an empty result register never blocks input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("result dropped or changed while stalled");

	// error status sticks until the line ends
	a_status_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !prev_done_q && prev_status_q != ST_OK |-> status == prev_status_q)
		else $error("status cleared inside a line");

	// count moves by at most one per byte within a line
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !prev_done_q && COUNT_BITS <= 16 |->
			count == prev_count_q || count == prev_count_q + 16'd1)
		else $error("count jumped within a line");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_MISMATCH || status == ST_OVERFLOW)
		else $error("undefined status code");

endmodule

bind sparse_vector_token_counter svtc_checker #(.COUNT_BITS(COUNT_BITS)) u_svtc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_byte  (results.out_byte),
	.count     (results.count),
	.status    (results.status),
	.done_res  (results.done_res)
);
